// File: hw/rtl/ptmw_pkg.sv
// Shared constants, types and state codes for the trimmed-mean pH window unit.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package ptmw_pkg;

   // Window geometry.
   localparam int WINDOW_LENGTH = 40;
   localparam int ADDR_W        = $clog2(WINDOW_LENGTH);

   // Field widths.
   localparam int SAMPLE_W = 10;
   localparam int OFFSET_W = 12;
   localparam int VOLT_W   = 13;
   localparam int PH_W     = 16;

   // Stream bus widths, rounded up to whole bytes.
   localparam int REQ_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((VOLT_W + PH_W + 7) / 8) * 8;

   // Running sum of the whole window.
   localparam int SUM_W = $clog2(WINDOW_LENGTH * (1 << SAMPLE_W));

   // Scaling: value = floor(trimmed * SCALE / (1024 * DIVISOR)).
   localparam int VOLT_SCALE = 5000;
   localparam int PH_SCALE   = 17500;
   localparam int SCALE_W    = 15;
   localparam int REF_SHIFT  = 10;
   localparam int PROD_W     = SUM_W + SCALE_W;
   localparam int NUM_W      = PROD_W - REF_SHIFT;

   // Division by the trimmed count through a truncated reciprocal. Three guard
   // bits keep the estimate at most one below the true quotient.
   localparam int     DIVISOR     = WINDOW_LENGTH - 2;
   localparam int     RECIP_SHIFT = NUM_W + 3;
   localparam int     RECIP_W     = RECIP_SHIFT;
   localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / DIVISOR;
   localparam int     QUOT_W      = 15;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_LAST,
      ST_TRIM,
      ST_SCALE_V,
      ST_SCALE_P,
      ST_WAIT,
      ST_DONE
   } seq_state_type;

   // One cycle of requests to the window memory.
   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [SAMPLE_W-1:0] wr_data;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
   } win_req_type;

endpackage

`default_nettype wire

// File: hw/rtl/ptmw_window_ram.sv
// Sample window memory: one write and one registered read per cycle.
// Depends on ptmw_pkg; entries never written since reset read as zero.
`default_nettype none

module ptmw_window_ram
   import ptmw_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire win_req_type         req,
   output logic [SAMPLE_W-1:0]      rd_data
);

   logic [SAMPLE_W-1:0]      mem [WINDOW_LENGTH];
   logic [WINDOW_LENGTH-1:0] valid_ff;
   logic [WINDOW_LENGTH-1:0] valid_in;
   logic [SAMPLE_W-1:0]      rd_data_ff;
   logic                     rd_hit_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
         rd_hit_ff  <= valid_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// File: hw/rtl/ptmw_recip_div.sv
// Three-stage divider by the constant trimmed count, using a reciprocal
// multiply and a single correction step. Depends on ptmw_pkg.
`default_nettype none

module ptmw_recip_div
   import ptmw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   output logic                   out_valid,
   output logic [QUOT_W-1:0]      out_quot
);

   localparam int MUL_W = NUM_W + RECIP_W;

   logic [MUL_W-1:0]  prod_ff;
   logic [MUL_W-1:0]  prod_in;
   logic [NUM_W-1:0]  x1_ff;
   logic [NUM_W-1:0]  x2_ff;
   logic [QUOT_W-1:0] q0_ff;
   logic [QUOT_W-1:0] q0_in;
   logic [QUOT_W-1:0] quot_ff;
   logic [QUOT_W-1:0] quot_in;
   logic [NUM_W-1:0]  rem;
   logic [2:0]        valid_ff;
   logic [2:0]        valid_in;

   assign prod_in  = MUL_W'(in_num) * MUL_W'(RECIP);
   assign q0_in    = prod_ff[RECIP_SHIFT +: QUOT_W];
   // The estimate is the true quotient or one below it.
   assign rem      = x2_ff - NUM_W'(NUM_W'(q0_ff) * NUM_W'(DIVISOR));
   assign quot_in  = (rem >= NUM_W'(DIVISOR)) ? q0_ff + 1'b1 : q0_ff;
   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      x1_ff   <= in_num;
      x2_ff   <= x1_ff;
      q0_ff   <= q0_in;
      quot_ff <= quot_in;
   end

   assign out_valid = valid_ff[2];
   assign out_quot  = quot_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ph_trimmed_mean_window_unit.sv
// Top level of the trimmed-mean pH window unit: sequencer, window sweep,
// scaling and output register. Depends on ptmw_pkg, ptmw_window_ram, ptmw_recip_div.
//
// Each req transaction carries one 10-bit converter sample. The sample is
// written into a circular window of WINDOW_LENGTH entries, and the whole window
// is read back one entry per cycle, summing it and tracking its smallest and
// largest entry. The trimmed sum (minus one minimum and one maximum) is scaled
// to millivolts and to pH in thousandths through a shared reciprocal divider,
// and the calibration offset is added. Each sample yields exactly one rsp
// transaction.
// Timing: rsp_tvalid rises after the window sweep, the trim, the scaling and the
// divider, the one-entry-per-cycle sweep taking most of that time.
// The next sample is taken in the cycle after the result is loaded, so a new
// sample is not accepted while one is in progress. A result the receiver has not
// taken waits in the output register while the next sample is accepted and
// processed; only the load of that next result waits for the register to drain.
// Reset clears the window (unwritten entries count as zero), the write position
// and the offset register. The offset (csr_) should be written only while no
// transaction is in flight.
`default_nettype none

module ph_trimmed_mean_window_unit
   import ptmw_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Sample input. req_tdata: [9:0] adc_sample, upper bits zero.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // Result output. rsp_tdata: [12:0] voltage_mv, [28:13] ph_milli, upper bits zero.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // Calibration offset register, signed thousandths of a pH unit.
   input  wire logic                   csr_wr_en,
   input  wire logic [OFFSET_W-1:0]    csr_wr_data
);

   seq_state_type       state_ff;
   seq_state_type       state_in;

   logic [OFFSET_W-1:0] offset_ff;
   logic [OFFSET_W-1:0] offset_in;
   logic [ADDR_W-1:0]   wp_ff;
   logic [ADDR_W-1:0]   wp_in;
   logic [ADDR_W-1:0]   idx_ff;
   logic [ADDR_W-1:0]   idx_in;
   logic                rd_valid_ff;
   logic                rd_valid_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [SAMPLE_W-1:0] lo_ff;
   logic [SAMPLE_W-1:0] lo_in;
   logic [SAMPLE_W-1:0] hi_ff;
   logic [SAMPLE_W-1:0] hi_in;
   logic [SUM_W-1:0]    trim_ff;
   logic [SUM_W-1:0]    trim_in;
   logic [NUM_W-1:0]    num_ff;
   logic [NUM_W-1:0]    num_in;
   logic                num_valid_ff;
   logic                num_valid_in;
   logic                res_sel_ff;
   logic                res_sel_in;
   logic [QUOT_W-1:0]   volt_q_ff;
   logic [QUOT_W-1:0]   volt_q_in;
   logic [QUOT_W-1:0]   ph_q_ff;
   logic [QUOT_W-1:0]   ph_q_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [VOLT_W-1:0]   rsp_volt_ff;
   logic [VOLT_W-1:0]   rsp_volt_in;
   logic [PH_W-1:0]     rsp_ph_ff;
   logic [PH_W-1:0]     rsp_ph_in;

   // Sequencer outputs.
   logic                accept;
   logic                sweep_rd;
   logic                start_acc;
   logic                do_trim;
   logic                scale_feed;
   logic                scale_ph;
   logic                load_rsp;

   win_req_type         win_req;
   logic [SAMPLE_W-1:0] win_rd_data;
   logic                div_valid;
   logic [QUOT_W-1:0]   div_quot;
   logic [PROD_W-1:0]   scale_prod;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (idx_ff == ADDR_W'(WINDOW_LENGTH - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST:    state_in = ST_TRIM;
         ST_TRIM:    state_in = ST_SCALE_V;
         ST_SCALE_V: state_in = ST_SCALE_P;
         ST_SCALE_P: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_valid && res_sel_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      sweep_rd   = 1'b0;
      do_trim    = 1'b0;
      scale_feed = 1'b0;
      scale_ph   = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_SWEEP:   sweep_rd   = 1'b1;
         ST_LAST:    ;
         ST_TRIM:    do_trim    = 1'b1;
         ST_SCALE_V: scale_feed = 1'b1;
         ST_SCALE_P: begin
            scale_feed = 1'b1;
            scale_ph   = 1'b1;
         end
         ST_WAIT:    ;
         ST_DONE:    load_rsp   = out_free;
         default:    ;
      endcase
   end

   assign accept    = req_tvalid && req_tready;
   assign start_acc = accept;

   // Window memory: the new sample is written in the accept cycle, the sweep
   // reads start in the following cycle so they always see it.
   always_comb begin
      win_req.wr_en   = accept;
      win_req.wr_addr = wp_ff;
      win_req.wr_data = req_tdata[SAMPLE_W-1:0];
      win_req.rd_en   = sweep_rd;
      win_req.rd_addr = idx_ff;
   end

   ptmw_window_ram u_window_ram (
      .clock   (clock),
      .reset   (reset),
      .req     (win_req),
      .rd_data (win_rd_data)
   );

   // Write position and sweep index.
   always_comb begin
      wp_in  = wp_ff;
      idx_in = idx_ff;
      if (accept) begin
         wp_in  = (wp_ff == ADDR_W'(WINDOW_LENGTH - 1)) ? '0 : wp_ff + 1'b1;
         idx_in = '0;
      end else if (sweep_rd) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   assign rd_valid_in = sweep_rd;

   // Sum, minimum and maximum over the read-back data. Starting the minimum
   // at all ones and the maximum at zero gives the same extremes as seeding
   // them from the first entry.
   always_comb begin
      sum_in = sum_ff;
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      if (start_acc) begin
         sum_in = '0;
         lo_in  = '1;
         hi_in  = '0;
      end else if (rd_valid_ff) begin
         sum_in = sum_ff + SUM_W'(win_rd_data);
         if (win_rd_data < lo_ff) begin
            lo_in = win_rd_data;
         end
         if (win_rd_data > hi_ff) begin
            hi_in = win_rd_data;
         end
      end
   end

   assign trim_in = do_trim ? sum_ff - SUM_W'(lo_ff) - SUM_W'(hi_ff) : trim_ff;

   // One shared constant multiplier; the product is registered before the
   // divider's own reciprocal multiply.
   assign scale_prod   = PROD_W'(trim_ff) *
                         (scale_ph ? PROD_W'(PH_SCALE) : PROD_W'(VOLT_SCALE));
   assign num_in       = scale_prod[PROD_W-1:REF_SHIFT];
   assign num_valid_in = scale_feed;

   ptmw_recip_div u_recip_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid_ff),
      .in_num    (num_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot)
   );

   // Quotients come back in issue order: voltage first, then pH.
   assign res_sel_in = div_valid ? !res_sel_ff : res_sel_ff;
   assign volt_q_in  = (div_valid && !res_sel_ff) ? div_quot : volt_q_ff;
   assign ph_q_in    = (div_valid && res_sel_ff) ? div_quot : ph_q_ff;

   // Output register.
   assign rsp_volt_in = load_rsp ? VOLT_W'(volt_q_ff) : rsp_volt_ff;
   assign rsp_ph_in   = load_rsp ?
                        PH_W'(ph_q_ff) +
                        {{(PH_W - OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff} :
                        rsp_ph_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign offset_in = csr_wr_en ? csr_wr_data : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= '0;
         wp_ff        <= '0;
         rd_valid_ff  <= 1'b0;
         num_valid_ff <= 1'b0;
         res_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         wp_ff        <= wp_in;
         rd_valid_ff  <= rd_valid_in;
         num_valid_ff <= num_valid_in;
         res_sel_ff   <= res_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      trim_ff     <= trim_in;
      num_ff      <= num_in;
      volt_q_ff   <= volt_q_in;
      ph_q_ff     <= ph_q_in;
      rsp_volt_ff <= rsp_volt_in;
      rsp_ph_ff   <= rsp_ph_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - VOLT_W - PH_W)'(0), rsp_ph_ff, rsp_volt_ff};

   // The write position always points inside the window.
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff < ADDR_W'(WINDOW_LENGTH))
      else $error("write position outside the window");

   // Memory read data only arrives while the sweep is running.
   a_rd_in_sweep: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SWEEP || state_ff == ST_LAST))
      else $error("window read data outside the sweep");

   // Divider results only return while the sequencer waits for them.
   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> state_ff == ST_WAIT)
      else $error("divider result outside the wait state");

   // A result is loaded only into an empty or draining output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> state_ff == ST_DONE)
      else $error("result loaded over an untaken transaction");

endmodule

`default_nettype wire
